// ===== design/adc_raw_to_millivolt_curve_defines.svh =====
// assertion macros shared by the checker
`ifndef ADC_RAW_TO_MILLIVOLT_CURVE_DEFINES_SVH
`define ADC_RAW_TO_MILLIVOLT_CURVE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define AMC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("amc check failed");

// next-cycle implication, sampled on clk, off during reset
`define AMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("amc check failed");

`endif

// ===== design/amc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package amc_pkg;

  // register map
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN      = 3'd0,
    CFG_OFFSET    = 3'd1,
    CFG_CONST     = 3'd2,
    CFG_NUM1      = 3'd3,
    CFG_DEN1      = 3'd4,
    CFG_NUM2      = 3'd5,
    CFG_DEN2      = 3'd6,
    CFG_TERM_CTRL = 3'd7
  } cfg_idx_t;

  // field widths
  localparam int GAIN_W     = 20;
  localparam int GAIN_SHIFT = 16;
  localparam int OFFS_W     = 13;
  localparam int DIV_W      = 64;
  localparam int HALF_W     = 32;
  localparam int MV_W       = 32;
  localparam int TCTRL_W    = 4;

  // reset values
  localparam logic [GAIN_W-1:0] GAIN_RST = 20'd65536;
  localparam logic [DIV_W-1:0]  DEN_RST  = 64'd1;

  // error polynomial coefficients
  typedef struct packed {
    logic [DIV_W-1:0] num1;
    logic [DIV_W-1:0] den1;
    logic [DIV_W-1:0] num2;
    logic [DIV_W-1:0] den2;
  } coef_t;

endpackage
`default_nettype wire

// ===== design/adc_raw_to_millivolt_curve.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   | port group | payload (lsb first)
// input     | in_*       | raw_code[ADC_BITS-1:0], zero padded to bytes
// output    | out_*      | millivolts[31:0]
// config    | cfg_*      | cfg_addr = register index, cfg_wdata = value
//
// one item per cycle sustained while the output is not stalled; five front-end stages
// (clamp, gain, square, partial products, sum), 64 division cells, output.
// the 64-cell restoring divider chain sets the latency.
// rst_n is synchronous; it clears valid bits and config registers.
// a stalled output holds the whole pipeline, and in_tready drops with it.
module adc_raw_to_millivolt_curve import amc_pkg::*; #(
  parameter int ADC_BITS  = 12,
  parameter int MAX_TERMS = 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [((ADC_BITS+7)/8)*8-1:0]     in_tdata,   // raw_code
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [MV_W-1:0]                        out_tdata,  // millivolts
  input  wire logic                              cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]              cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]             cfg_wdata
);

  localparam int V_W = ADC_BITS + GAIN_W - GAIN_SHIFT;

  logic [GAIN_W-1:0]  gain_r;
  logic [OFFS_W-1:0]  offset_r;
  logic [MV_W-1:0]    const_r;
  coef_t              coef_r;
  logic [TCTRL_W-1:0] tctrl_r;

  logic               adv;
  logic               pv, cv;
  logic [V_W-1:0]     pv_v, cv_v;
  logic [DIV_W-1:0]   dvd1, dvd2, quo1, quo2;
  logic [1:0]         cnt;
  logic [MV_W-1:0]    t1, t2, err, mv_nxt;
  logic               out_tvalid_r;
  logic [MV_W-1:0]    out_tdata_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_RST;
      offset_r    <= '0;
      const_r     <= '0;
      coef_r.num1 <= '0;
      coef_r.den1 <= DEN_RST;
      coef_r.num2 <= '0;
      coef_r.den2 <= DEN_RST;
      tctrl_r     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_GAIN:      gain_r      <= cfg_wdata[GAIN_W-1:0];
        CFG_OFFSET:    offset_r    <= cfg_wdata[OFFS_W-1:0];
        CFG_CONST:     const_r     <= cfg_wdata[MV_W-1:0];
        CFG_NUM1:      coef_r.num1 <= cfg_wdata;
        CFG_DEN1:      coef_r.den1 <= cfg_wdata;
        CFG_NUM2:      coef_r.num2 <= cfg_wdata;
        CFG_DEN2:      coef_r.den2 <= cfg_wdata;
        CFG_TERM_CTRL: tctrl_r     <= cfg_wdata[TCTRL_W-1:0];
        default:       ;
      endcase
    end
  end

  // whole pipeline moves when the output register is free
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  amc_prep #(.ADC_BITS(ADC_BITS)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_tvalid),
    .raw      (in_tdata[ADC_BITS-1:0]),
    .gain     (gain_r),
    .offset   (offset_r),
    .coef     (coef_r),
    .out_valid(pv),
    .v        (pv_v),
    .dvd1     (dvd1),
    .dvd2     (dvd2)
  );

  amc_div_chain #(.V_W(V_W)) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (pv),
    .v_in     (pv_v),
    .dvd1     (dvd1),
    .dvd2     (dvd2),
    .coef     (coef_r),
    .out_valid(cv),
    .v_out    (cv_v),
    .quo1     (quo1),
    .quo2     (quo2)
  );

  // term count saturates at MAX_TERMS
  assign cnt = (tctrl_r[1:0] > 2'(MAX_TERMS)) ? 2'(MAX_TERMS) : tctrl_r[1:0];

  // zero denominator gives zero term
  assign t1 = (coef_r.den1 == '0) ? '0 : quo1[MV_W-1:0];
  assign t2 = (coef_r.den2 == '0) ? '0 : quo2[MV_W-1:0];

  // error sum and final subtract
  always_comb begin
    err = '0;
    if (cv_v != '0 && cnt != 2'd0) begin
      err = const_r;
      if (cnt >= 2'd2) begin
        err = tctrl_r[2] ? err - t1 : err + t1;
      end
      if (cnt >= 2'd3) begin
        err = tctrl_r[3] ? err - t2 : err + t2;
      end
    end
    mv_nxt = MV_W'(cv_v) - err;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= cv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= mv_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire

// ===== design/amc_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none
module amc_prep import amc_pkg::*; #(
  parameter int ADC_BITS = 12
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   en,
  input  wire logic                                   in_valid,
  input  wire logic [ADC_BITS-1:0]                    raw,
  input  wire logic [GAIN_W-1:0]                      gain,
  input  wire logic [OFFS_W-1:0]                      offset,
  input  wire coef_t                                  coef,
  output logic                                        out_valid,
  output logic [ADC_BITS+GAIN_W-GAIN_SHIFT-1:0]       v,
  output logic [DIV_W-1:0]                            dvd1,
  output logic [DIV_W-1:0]                            dvd2
);

  localparam int V_W  = ADC_BITS + GAIN_W - GAIN_SHIFT;
  localparam int DW   = ((ADC_BITS > OFFS_W) ? ADC_BITS : OFFS_W) + 2;
  localparam int NSTG = 5;

  logic signed [DW-1:0]   diff;
  logic [ADC_BITS-1:0]    code_nxt, code_r;
  logic [ADC_BITS+GAIN_W-1:0] prod;
  logic [V_W-1:0]         v_b_r, v_c_r, v_d_r, v_e_r;
  logic [2*V_W-1:0]       vsq_c_r;
  logic [DIV_W-1:0]       p1lo_r, p2lo_r;
  logic [HALF_W-1:0]      p1hi_r, p2hi_r;
  logic [DIV_W-1:0]       dvd1_r, dvd2_r;
  logic [NSTG-1:0]        vld_r;

  // offset subtract and clamp to converter range
  assign diff = $signed({{(DW-ADC_BITS){1'b0}}, raw}
                      - {{(DW-OFFS_W){offset[OFFS_W-1]}}, offset});

  always_comb begin
    if (diff[DW-1]) begin
      code_nxt = '0;
    end else if (diff[DW-2:0] > {{(DW-1-ADC_BITS){1'b0}}, {ADC_BITS{1'b1}}}) begin
      code_nxt = {ADC_BITS{1'b1}};
    end else begin
      code_nxt = diff[ADC_BITS-1:0];
    end
  end

  // linear gain, floor by 2^16
  assign prod = {{GAIN_W{1'b0}}, code_r} * {{ADC_BITS{1'b0}}, gain};

  // valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      code_r  <= code_nxt;
      v_b_r   <= prod[ADC_BITS+GAIN_W-1:GAIN_SHIFT];
      v_c_r   <= v_b_r;
      vsq_c_r <= {{V_W{1'b0}}, v_b_r} * {{V_W{1'b0}}, v_b_r};
      v_d_r   <= v_c_r;
      p1lo_r  <= DIV_W'({{HALF_W{1'b0}}, v_c_r} * {{V_W{1'b0}}, coef.num1[HALF_W-1:0]});
      p1hi_r  <= HALF_W'({{HALF_W{1'b0}}, v_c_r} * {{V_W{1'b0}}, coef.num1[DIV_W-1:HALF_W]});
      p2lo_r  <= DIV_W'({{HALF_W{1'b0}}, vsq_c_r} * {{(2*V_W){1'b0}}, coef.num2[HALF_W-1:0]});
      p2hi_r  <= HALF_W'({{HALF_W{1'b0}}, vsq_c_r}
                         * {{(2*V_W){1'b0}}, coef.num2[DIV_W-1:HALF_W]});
      v_e_r   <= v_d_r;
      dvd1_r  <= p1lo_r + {p1hi_r, {HALF_W{1'b0}}};
      dvd2_r  <= p2lo_r + {p2hi_r, {HALF_W{1'b0}}};
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign v         = v_e_r;
  assign dvd1      = dvd1_r;
  assign dvd2      = dvd2_r;

endmodule
`default_nettype wire

// ===== design/amc_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module amc_div_cell import amc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [DIV_W-1:0] den,
  input  wire logic [DIV_W-1:0] rem_i,
  input  wire logic [DIV_W-1:0] dq_i,
  output logic [DIV_W-1:0]      rem_o,
  output logic [DIV_W-1:0]      dq_o
);

  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   trial;
  logic             ge;
  logic [DIV_W-1:0] rem_nxt, dq_nxt;
  logic [DIV_W-1:0] rem_r, dq_r;

  // one restoring step: bring in next dividend bit, try subtract
  assign shifted = {rem_i, dq_i[DIV_W-1]};
  assign trial   = shifted - {1'b0, den};
  assign ge      = !trial[DIV_W];
  assign rem_nxt = ge ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
  assign dq_nxt  = {dq_i[DIV_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign rem_o = rem_r;
  assign dq_o  = dq_r;

endmodule
`default_nettype wire

// ===== design/amc_div_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
module amc_div_chain import amc_pkg::*; #(
  parameter int V_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [V_W-1:0]   v_in,
  input  wire logic [DIV_W-1:0] dvd1,
  input  wire logic [DIV_W-1:0] dvd2,
  input  wire coef_t            coef,
  output logic                  out_valid,
  output logic [V_W-1:0]        v_out,
  output logic [DIV_W-1:0]      quo1,
  output logic [DIV_W-1:0]      quo2
);

  logic [DIV_W-1:0] rem1 [0:DIV_W];
  logic [DIV_W-1:0] dq1  [0:DIV_W];
  logic [DIV_W-1:0] rem2 [0:DIV_W];
  logic [DIV_W-1:0] dq2  [0:DIV_W];
  logic [V_W-1:0]   vs   [0:DIV_W];
  logic [DIV_W:0]   vld;

  assign rem1[0] = '0;
  assign dq1[0]  = dvd1;
  assign rem2[0] = '0;
  assign dq2[0]  = dvd2;
  assign vs[0]   = v_in;
  assign vld[0]  = in_valid;

  // one quotient bit per cell, both terms side by side
  for (genvar g = 0; g < DIV_W; g++) begin : g_cell
    amc_div_cell u_c1 (
      .clk  (clk),
      .en   (en),
      .den  (coef.den1),
      .rem_i(rem1[g]),
      .dq_i (dq1[g]),
      .rem_o(rem1[g+1]),
      .dq_o (dq1[g+1])
    );
    amc_div_cell u_c2 (
      .clk  (clk),
      .en   (en),
      .den  (coef.den2),
      .rem_i(rem2[g]),
      .dq_i (dq2[g]),
      .rem_o(rem2[g+1]),
      .dq_o (dq2[g+1])
    );

    // sideband travels with the cell
    always_ff @(posedge clk) begin
      if (en) begin
        vs[g+1] <= vs[g];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end
  end

  assign out_valid = vld[DIV_W];
  assign v_out     = vs[DIV_W];
  assign quo1      = dq1[DIV_W];
  assign quo2      = dq2[DIV_W];

endmodule
`default_nettype wire

// ===== design/amc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "adc_raw_to_millivolt_curve_defines.svh"
module amc_sva (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // stalled result holds
  `AMC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // empty output register never blocks input
  `AMC_ASSERT_NOW(a_ready_empty, !out_tvalid, in_tready)

  // a taken result frees the input the same cycle
  `AMC_ASSERT_NOW(a_ready_take, out_tvalid && out_tready, in_tready)

  // a stalled result stops intake
  `AMC_ASSERT_NOW(a_stall_block, out_tvalid && !out_tready, !in_tready)

endmodule

bind adc_raw_to_millivolt_curve amc_sva u_amc_sva (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
`default_nettype wire

// ===== tb/amc_checker.sv =====
`timescale 1ns / 1ps
module amc_checker import amc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [15:0]           in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [MV_W-1:0]       out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending_count
);

  // shadow copy of the calibration registers
  logic [GAIN_W-1:0]  gain;
  logic [OFFS_W-1:0]  offset;
  logic [31:0]        const_term;
  logic [63:0]        num1, den1, num2, den2;
  logic [TCTRL_W-1:0] tctrl;

  logic [31:0] expected_mv[$];

  // linear estimate minus polynomial error
  function automatic logic [31:0] calc_millivolts(input logic [11:0] raw);
    logic signed [15:0] code;
    logic [63:0]        v, vsq;
    logic [31:0]        err, t;
    logic [1:0]         count;
    code = $signed({4'd0, raw}) - $signed({{3{offset[OFFS_W-1]}}, offset});
    if (code < 0) code = 0;
    if (code > 4095) code = 4095;
    v = (64'(code) * 64'(gain)) >> GAIN_SHIFT;
    count = tctrl[1:0];
    err = '0;
    if (v != 0 && count != 0) begin
      err = const_term;
      if (count >= 2) begin
        t = (den1 == 0) ? 32'd0 : 32'((v * num1) / den1);
        err = tctrl[2] ? err - t : err + t;
      end
      if (count >= 3) begin
        vsq = v * v;
        t = (den2 == 0) ? 32'd0 : 32'((vsq * num2) / den2);
        err = tctrl[3] ? err - t : err + t;
      end
    end
    return v[31:0] - err;
  endfunction

  assign pending_count = expected_mv.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      gain <= GAIN_RST;
      offset <= '0;
      const_term <= '0;
      num1 <= '0;
      den1 <= DEN_RST;
      num2 <= '0;
      den2 <= DEN_RST;
      tctrl <= '0;
      expected_mv.delete();
      fail_count <= 0;
    end else begin
      // register writes
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_GAIN:      gain <= cfg_wdata[GAIN_W-1:0];
          CFG_OFFSET:    offset <= cfg_wdata[OFFS_W-1:0];
          CFG_CONST:     const_term <= cfg_wdata[31:0];
          CFG_NUM1:      num1 <= cfg_wdata;
          CFG_DEN1:      den1 <= cfg_wdata;
          CFG_NUM2:      num2 <= cfg_wdata;
          CFG_DEN2:      den2 <= cfg_wdata;
          CFG_TERM_CTRL: tctrl <= cfg_wdata[TCTRL_W-1:0];
          default: ;
        endcase
      end
      // input transaction
      if (in_tvalid && in_tready)
        expected_mv.push_back(calc_millivolts(in_tdata[11:0]));
      // output transaction
      if (out_tvalid && out_tready) begin
        if (expected_mv.size() == 0) begin
          $error("millivolts: unexpected result %0d", $signed(out_tdata));
          fail_count <= fail_count + 1;
        end else begin
          if (out_tdata !== expected_mv[0]) begin
            $error("millivolts: expected %0d actual %0d",
                   $signed(expected_mv[0]), $signed(out_tdata));
            fail_count <= fail_count + 1;
          end
          void'(expected_mv.pop_front());
        end
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import amc_pkg::*;

  localparam int LATENCY = 70;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;   // raw_code[11:0], zero padded
  logic                  out_tvalid;
  logic                  out_tready;
  logic [MV_W-1:0]       out_tdata;  // millivolts[31:0]
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending_count;
  int                    send_idle_pct;
  int                    recv_idle_pct;
  bit                    sending;

  adc_raw_to_millivolt_curve u_top (.*);

  amc_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stalls
  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_idle_pct);

  // write one register while idle
  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one raw code, with random gaps ahead of it
  task automatic send_code(input logic [11:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, raw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // drain the pipeline before touching registers
  task automatic wait_idle;
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  function automatic logic [11:0] pick_code;
    case ($urandom_range(3))
      0: return 12'($urandom_range(15));
      1: return 12'(4095 - $urandom_range(15));
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pick_wide;
    case ($urandom_range(4))
      0: return 64'($urandom_range(1000));
      1: return {$urandom, $urandom};
      2: return 64'hFFFF_FFFF_FFFF_FFFF;
      default: return 64'($urandom);
    endcase
  endfunction

  task automatic random_config;
    write_reg(CFG_GAIN, ($urandom_range(3) == 0) ? 64'(20'hFFFFF) : 64'($urandom_range(131072)));
    write_reg(CFG_OFFSET, 64'($signed(13'($urandom_range(8190)) - 13'sd4095)));
    write_reg(CFG_CONST, 64'($urandom));
    write_reg(CFG_NUM1, pick_wide());
    write_reg(CFG_DEN1, ($urandom_range(5) == 0) ? 64'd0 : pick_wide());
    write_reg(CFG_NUM2, pick_wide());
    write_reg(CFG_DEN2, ($urandom_range(5) == 0) ? 64'd0 : pick_wide());
    write_reg(CFG_TERM_CTRL, 64'($urandom_range(15)));
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    send_idle_pct = 18;
    recv_idle_pct = 82;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, code extremes
    send_code(12'd0);
    send_code(12'd1);
    send_code(12'd4095);
    send_code(12'hAAA);
    send_code(12'h555);
    wait_idle();
    // full polynomial, largest gain, negative offset clamps high
    write_reg(CFG_GAIN, 64'hFFFFF);
    write_reg(CFG_OFFSET, 64'h1001);
    write_reg(CFG_CONST, 64'h8000_0000);
    write_reg(CFG_NUM1, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_DEN1, 64'd3);
    write_reg(CFG_NUM2, 64'd7);
    write_reg(CFG_DEN2, 64'd0);
    write_reg(CFG_TERM_CTRL, 64'd15);
    send_code(12'd0);
    send_code(12'd4095);
    send_code(12'd100);
    wait_idle();
    // positive offset clamps low, zero gain gives zero estimate
    write_reg(CFG_OFFSET, 64'd4095);
    write_reg(CFG_DEN2, 64'd5);
    write_reg(CFG_TERM_CTRL, 64'd3);
    send_code(12'd4095);
    send_code(12'd10);
    wait_idle();
    write_reg(CFG_GAIN, 64'd0);
    write_reg(CFG_OFFSET, 64'd0);
    write_reg(CFG_TERM_CTRL, 64'd6);
    send_code(12'd4095);
    wait_idle();
    write_reg(CFG_GAIN, 64'd65536);
    write_reg(CFG_TERM_CTRL, 64'd1);
    send_code(12'd2048);
    wait_idle();
    write_reg(CFG_TERM_CTRL, 64'd2);
    send_code(12'd2048);

    // random phases: sender idles little, then much, then not at all
    for (int phase = 0; phase < 11; phase++) begin
      wait_idle();
      if (phase == 4) begin
        send_idle_pct = 82;
        recv_idle_pct = 18;
      end else if (phase == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_config();
      for (int n = 0; n < 48; n++) send_code(pick_code());
    end

    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/amc_pkg.sv
design/amc_prep.sv
design/amc_div_cell.sv
design/amc_div_chain.sv
design/adc_raw_to_millivolt_curve.sv
design/amc_checker.sv
tb/amc_checker.sv
tb/testbench.sv
